FILE: design/bba_pkg.sv
// Package for the bitmap block allocator: field widths, constants, payload
// structs, controller states and the command and status bundles.
// No dependencies; every other design file but bba_ram imports it.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  // Field widths of the transactions and of the block size register.
  localparam int unsigned SIZE_W    = 13;
  localparam int unsigned BYTES_W   = 19;
  localparam int unsigned OFF_W     = 18;

  // Block size after reset, and the largest byte offset a result can carry.
  localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd64;
  localparam logic [OFF_W-1:0]  OFF_MAX    = 18'h3FFFF;

  // The divider retires one quotient bit per step over the widest dividend.
  localparam int unsigned DIV_STEPS = BYTES_W;
  localparam int unsigned DIV_CNT_W = 5;

  // Action codes of an input transaction.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef struct packed {
    logic               action;
    logic [BYTES_W-1:0] byte_count;
    logic [OFF_W-1:0]   byte_offset;
  } item_t;

  typedef struct packed {
    logic             ok;
    logic [OFF_W-1:0] alloc_offset;
  } result_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV_CNT,
    ST_NEED,
    ST_DIV_OFF,
    ST_FIRST,
    ST_FREE,
    ST_SCAN,
    ST_MUL,
    ST_CHECK,
    ST_MARK,
    ST_RESP
  } bba_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // latch the item and load the divider with its byte count
    logic div_step;    // retire one quotient bit
    logic need_load;   // keep the block count and reload the divider with the offset
    logic scan_run;    // walk the use map looking for a free run
    logic mul;         // form the byte offset of the found run
    logic check;       // commit the result if the offset fits
    logic wr_load;     // load the write pointer and the remaining block count
    logic wr_from_quo; // take the write pointer from the quotient, not the scan
    logic wr_run;      // write one map bit and advance
    logic wr_val;      // value written to the map
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_zero;   // zero block size or zero byte count on the offered item
    logic is_free;   // the latched item frees a run
    logic div_last;  // the divider is on its final step
    logic need_big;  // block count exceeds the pool
    logic off_out;   // first block to free lies past the pool
    logic scan_hit;  // a long enough free run has been found
    logic scan_end;  // last block checked without a hit
    logic fit;       // the run offset fits the result field
    logic wr_end;    // write pointer is on the last block
    logic rem_last;  // one block left to write
  } sts_t;

endpackage : bba_pkg

`default_nettype wire

FILE: design/bitmap_block_allocator.sv
// Bitmap first-fit block allocator. A transaction with a zero block size or byte count goes
// straight to its result; an allocate runs a 19-step divider, reads one map bit per cycle
// and writes one bit per cycle; a free also divides its offset, then clears its blocks in turn.
// One transaction at a time; the result strobe lasts one cycle and cannot be stalled.
// After reset the use map is cleared with busy high; block size is 64.
// Depends on bba_pkg, bba_ctrl, bba_dp and bba_ram.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_block_allocator #(
  parameter int unsigned BLOCK_TOTAL = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire bba_pkg::item_t             item_i,
  output logic                            done_o,
  output bba_pkg::result_t                result_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [bba_pkg::SIZE_W-1:0] cfg_wdata_i
);

  import bba_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // Controller.
  bba_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .ctl_o  (ctl),
    .busy_o (busy),
    .done_o (done_o)
  );

  // Datapath with the use map.
  bba_dp #(
    .BLOCK_TOTAL(BLOCK_TOTAL)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .item_i     (item_i),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .result_o   (result_o)
  );

`ifndef SYNTHESIS
  // An accepted transaction keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted transaction");

  // A result is only shown while a transaction is in flight.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe while idle");

  // The block is ready again right after the result strobe.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!busy && !done_o))
    else $error("block not idle after the result");

  // A failed allocation reports offset zero.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.ok) |-> (result_o.alloc_offset == '0))
    else $error("non-zero offset on a failed allocation");
`endif

endmodule : bitmap_block_allocator

`default_nettype wire

FILE: design/bba_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bba_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule : bba_ram

`default_nettype wire

FILE: design/bba_ctrl.sv
// Controller of the bitmap block allocator: sequences the clearing pass,
// the division, the map scan and the map writes. Depends on bba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bba_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire bba_pkg::sts_t sts_i,
  output bba_pkg::ctl_t      ctl_o,
  output logic               busy_o,
  output logic               done_o
);

  import bba_pkg::*;

  bba_state_e state_q, state_d;

  // State register; reset starts the clearing pass over the map.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.wr_end) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) state_d = sts_i.in_zero ? ST_RESP : ST_DIV_CNT;
      end
      ST_DIV_CNT: begin
        if (sts_i.div_last) state_d = ST_NEED;
      end
      ST_NEED: begin
        if (sts_i.is_free) begin
          state_d = ST_DIV_OFF;
        end else if (sts_i.need_big) begin
          state_d = ST_RESP;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_DIV_OFF: begin
        if (sts_i.div_last) state_d = ST_FIRST;
      end
      ST_FIRST: begin
        state_d = sts_i.off_out ? ST_RESP : ST_FREE;
      end
      ST_FREE: begin
        if (sts_i.rem_last || sts_i.wr_end) state_d = ST_RESP;
      end
      ST_SCAN: begin
        if (sts_i.scan_hit) begin
          state_d = ST_MUL;
        end else if (sts_i.scan_end) begin
          state_d = ST_RESP;
        end
      end
      ST_MUL: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = sts_i.fit ? ST_MARK : ST_RESP;
      end
      ST_MARK: begin
        if (sts_i.rem_last) state_d = ST_RESP;
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    ctl_o  = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        ctl_o.wr_run = 1'b1;
        ctl_o.wr_val = 1'b0;
      end
      ST_IDLE: begin
        busy_o       = 1'b0;
        ctl_o.accept = start_i;
      end
      ST_DIV_CNT, ST_DIV_OFF: begin
        ctl_o.div_step = 1'b1;
      end
      ST_NEED: begin
        ctl_o.need_load = 1'b1;
      end
      ST_FIRST: begin
        ctl_o.wr_load     = 1'b1;
        ctl_o.wr_from_quo = 1'b1;
      end
      ST_FREE: begin
        ctl_o.wr_run = 1'b1;
        ctl_o.wr_val = 1'b0;
      end
      ST_SCAN: begin
        ctl_o.scan_run = 1'b1;
      end
      ST_MUL: begin
        ctl_o.mul = 1'b1;
      end
      ST_CHECK: begin
        ctl_o.check   = 1'b1;
        ctl_o.wr_load = 1'b1;
      end
      ST_MARK: begin
        ctl_o.wr_run = 1'b1;
        ctl_o.wr_val = 1'b1;
      end
      ST_RESP: begin
        done_o = 1'b1;
      end
      default: begin
        ctl_o = '0;
      end
    endcase
  end

endmodule : bba_ctrl

`default_nettype wire

FILE: design/bba_dp.sv
// Datapath of the bitmap block allocator: block size register, iterative
// divider, map scan, offset multiplier and map writer around the use map RAM.
// Depends on bba_pkg and bba_ram.
`timescale 1ns / 1ps
`default_nettype none

module bba_dp #(
  parameter int unsigned BLOCK_TOTAL = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [bba_pkg::SIZE_W-1:0]  cfg_wdata_i,
  input  wire bba_pkg::item_t              item_i,
  input  wire bba_pkg::ctl_t               ctl_i,
  output bba_pkg::sts_t                    sts_o,
  output bba_pkg::result_t                 result_o
);

  import bba_pkg::*;

  localparam int unsigned IdxW  = (BLOCK_TOTAL > 1) ? $clog2(BLOCK_TOTAL) : 1;
  localparam int unsigned CntW  = $clog2(BLOCK_TOTAL + 1);
  localparam int unsigned ProdW = IdxW + SIZE_W;
  localparam int unsigned CmpW  = (ProdW > OFF_W) ? ProdW : OFF_W;
  localparam logic [IdxW-1:0]    LastIdx  = IdxW'(BLOCK_TOTAL - 1);
  localparam logic [CntW-1:0]    TotalCnt = CntW'(BLOCK_TOTAL);
  localparam logic [BYTES_W:0]   TotalExt = (BYTES_W + 1)'(BLOCK_TOTAL);

  // Configuration and latched item.
  logic [SIZE_W-1:0]    size_q;
  logic                 act_q;
  logic [OFF_W-1:0]     offset_q;

  // Divider.
  logic [BYTES_W-1:0]   dvd_q;
  logic [SIZE_W-1:0]    rem_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [SIZE_W:0]      part;
  logic [SIZE_W:0]      diff;
  logic                 ge;
  logic [BYTES_W-1:0]   need_d;
  logic [BYTES_W-1:0]   need_q;

  // Scan.
  logic [CntW-1:0]      rd_q;
  logic [CntW-1:0]      run_q;
  logic [CntW:0]        run_inc;
  logic                 chk_vld_q;
  logic [IdxW-1:0]      chk_idx_q;
  logic                 issue;
  logic                 hit;
  logic [IdxW-1:0]      first_q;

  // Offset multiplier.
  logic [ProdW-1:0]     prod_q;
  logic [CmpW-1:0]      prod_ext;
  logic                 fit;

  // Map writer.
  logic [IdxW-1:0]      wr_q;
  logic [BYTES_W-1:0]   wr_rem_q;

  // Result.
  logic                 ok_q;
  logic [OFF_W-1:0]     off_q;

  logic                 map_rdata;

  // Block size register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  // One restoring division step: shift in the next dividend bit and subtract
  // the block size where it goes.
  assign part   = {rem_q, dvd_q[BYTES_W-1]};
  assign diff   = part - {1'b0, size_q};
  assign ge     = (part >= {1'b0, size_q});
  // Ceiling of the byte count over the block size; it cannot wrap.
  assign need_d = dvd_q + BYTES_W'(rem_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (ctl_i.accept || ctl_i.need_load) begin
      div_cnt_q <= '0;
    end else if (ctl_i.div_step) begin
      div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      act_q    <= item_i.action;
      offset_q <= item_i.byte_offset;
      dvd_q    <= item_i.byte_count;
      rem_q    <= '0;
    end else if (ctl_i.need_load) begin
      need_q   <= need_d;
      dvd_q    <= BYTES_W'(offset_q);
      rem_q    <= '0;
    end else if (ctl_i.div_step) begin
      dvd_q    <= {dvd_q[BYTES_W-2:0], ge};
      rem_q    <= ge ? diff[SIZE_W-1:0] : part[SIZE_W-1:0];
    end
  end

  // Map scan: reads are issued one block ahead of the check, so the run
  // counter sees the data in the cycle after its address.
  assign issue   = ctl_i.scan_run && (rd_q < TotalCnt);
  assign run_inc = {1'b0, run_q} + (CntW + 1)'(1);
  assign hit     = chk_vld_q && !map_rdata &&
                   ((BYTES_W + 1)'(run_inc) == {1'b0, need_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q      <= '0;
      run_q     <= '0;
      chk_vld_q <= 1'b0;
    end else if (!ctl_i.scan_run) begin
      rd_q      <= '0;
      run_q     <= '0;
      chk_vld_q <= 1'b0;
    end else begin
      chk_vld_q <= issue;
      if (issue) rd_q <= rd_q + CntW'(1);
      if (chk_vld_q) run_q <= map_rdata ? '0 : run_inc[CntW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= rd_q[IdxW-1:0];
    if (hit) begin
      first_q <= chk_idx_q - IdxW'(run_q);
    end
  end

  // Byte offset of the found run.
  always_ff @(posedge clk_i) begin
    if (ctl_i.mul) begin
      prod_q <= ProdW'(first_q) * ProdW'(size_q);
    end
  end

  assign prod_ext = CmpW'(prod_q);
  assign fit      = (prod_ext <= CmpW'(OFF_MAX));

  // Map writer, also used by the clearing pass after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
    end else if (ctl_i.wr_load) begin
      wr_q <= ctl_i.wr_from_quo ? dvd_q[IdxW-1:0] : first_q;
    end else if (ctl_i.wr_run) begin
      wr_q <= (wr_q == LastIdx) ? '0 : wr_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_load) begin
      wr_rem_q <= need_q;
    end else if (ctl_i.wr_run) begin
      wr_rem_q <= wr_rem_q - BYTES_W'(1);
    end
  end

  // Result registers; a free reports success from the start.
  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      ok_q  <= (item_i.action == ACT_FREE);
      off_q <= '0;
    end else if (ctl_i.check && fit) begin
      ok_q  <= 1'b1;
      off_q <= prod_ext[OFF_W-1:0];
    end
  end

  bba_ram #(
    .WIDTH(1),
    .DEPTH(BLOCK_TOTAL)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ctl_i.wr_run),
    .waddr_i(wr_q),
    .wdata_i(ctl_i.wr_val),
    .raddr_i(rd_q[IdxW-1:0]),
    .rdata_o(map_rdata)
  );

  // Status to the controller.
  always_comb begin
    sts_o          = '0;
    sts_o.in_zero  = (size_q == '0) || (item_i.byte_count == '0);
    sts_o.is_free  = (act_q == ACT_FREE);
    sts_o.div_last = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
    sts_o.need_big = ({1'b0, need_d} > TotalExt);
    sts_o.off_out  = ({1'b0, dvd_q} >= TotalExt);
    sts_o.scan_hit = hit;
    sts_o.scan_end = chk_vld_q && (chk_idx_q == LastIdx) && !hit;
    sts_o.fit      = fit;
    sts_o.wr_end   = (wr_q == LastIdx);
    sts_o.rem_last = (wr_rem_q == BYTES_W'(1));
  end

  assign result_o.ok           = ok_q;
  assign result_o.alloc_offset = off_q;

endmodule : bba_dp

`default_nettype wire

FILE: bench/bitmap_block_allocator_tb.sv
// Self-checking testbench for the bitmap block allocator: a directed table, then random
// allocate and free traffic over several block sizes, checked against a use-map predictor.
// Depends on bba_pkg and bitmap_block_allocator.
`timescale 1ns / 1ps

module bitmap_block_allocator_tb;
  import bba_pkg::*;

  localparam int unsigned POOL_BLOCKS = 64;
  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam longint unsigned MAX_BYTES = 262144;

  // One row of the directed table: either a block size write or a transaction.
  typedef struct packed {
    logic              is_cfg;
    logic [SIZE_W-1:0] size;
    item_t             item;
    logic              typed;
    result_t           want;
  } stim_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  item_t             item_i;
  logic              done_o;
  result_t           result_o;
  logic              cfg_we_i;
  logic [SIZE_W-1:0] cfg_wdata_i;

  // Predictor state: the use map and the block size as the block should hold them.
  logic [POOL_BLOCKS-1:0] use_map;
  logic [SIZE_W-1:0]      cur_size;

  result_t         pending_results[$];
  stim_row_t       dir_rows[$];
  logic [OFF_W-1:0] live_offset[$];
  logic [BYTES_W-1:0] live_bytes[$];

  result_t     want_res;
  int unsigned errors;
  int unsigned n_results;
  int unsigned n_sent;
  int unsigned n_granted;
  int unsigned n_refused;
  int unsigned n_released;
  int unsigned size_plan[9];

  bitmap_block_allocator #(
    .BLOCK_TOTAL(POOL_BLOCKS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Free-running clock, 2 ns period.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard limit on the run, several times the slowest correct run.
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    errors++;
    if (errors <= 40) begin
      $display("[%0t] result %0d: %s: got 0x%0h, expected 0x%0h",
               $time, n_results, what, got, want);
    end
  endtask

  // Writes a value to a run of use map bits, dropping blocks past the pool's end.
  function automatic void mark_blocks(longint unsigned first, longint unsigned count,
                                      logic val);
    longint unsigned k;
    for (k = 0; k < count && first + k < POOL_BLOCKS; k++) begin
      use_map[first + k] = val;
    end
  endfunction

  // Works out the result of one transaction and updates the predicted use map.
  function automatic result_t predict_result(item_t it);
    result_t         r;
    longint unsigned sz;
    longint unsigned cnt;
    longint unsigned need;
    longint unsigned run;
    longint unsigned first;
    longint unsigned addr;
    int unsigned     b;
    logic            settled;
    r = '0;
    sz = cur_size;
    cnt = it.byte_count;
    if (it.action == ACT_FREE) begin
      r.ok = 1'b1;
      if (sz != 0 && cnt != 0) begin
        mark_blocks(it.byte_offset / sz, (cnt + sz - 1) / sz, 1'b0);
      end
    end else if (sz != 0 && cnt != 0) begin
      // First fit: the lowest run of free blocks that is long enough.
      need = (cnt + sz - 1) / sz;
      run = 0;
      settled = 1'b0;
      for (b = 0; b < POOL_BLOCKS && !settled; b++) begin
        if (use_map[b]) begin
          run = 0;
        end else begin
          run++;
          if (run == need) begin
            settled = 1'b1;
            first = b + 1 - need;
            addr = first * sz;
            if (addr <= OFF_MAX) begin
              mark_blocks(first, need, 1'b1);
              r.ok = 1'b1;
              r.alloc_offset = addr[OFF_W-1:0];
            end
          end
        end
      end
    end
    return r;
  endfunction

  // Result checking: each strobed result is matched against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      n_results++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected", result_o, 0);
      end else begin
        want_res = pending_results.pop_front();
        if (result_o.ok !== want_res.ok) begin
          report_mismatch("ok", result_o.ok, want_res.ok);
        end
        if (result_o.alloc_offset !== want_res.alloc_offset) begin
          report_mismatch("alloc_offset", result_o.alloc_offset, want_res.alloc_offset);
        end
      end
    end
  end

  task automatic add_cfg(logic [SIZE_W-1:0] v);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.size = v;
    dir_rows.push_back(row);
  endtask

  task automatic add_item(logic act, logic [BYTES_W-1:0] cnt, logic [OFF_W-1:0] off,
                          logic typed, logic ok, logic [OFF_W-1:0] want_off);
    stim_row_t row;
    row = '0;
    row.item.action = act;
    row.item.byte_count = cnt;
    row.item.byte_offset = off;
    row.typed = typed;
    row.want.ok = ok;
    row.want.alloc_offset = want_off;
    dir_rows.push_back(row);
  endtask

  // Writes the block size once the block is idle and every result is in.
  task automatic write_block_size(logic [SIZE_W-1:0] v);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0 || busy) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cur_size = v;
    cfg_we_i <= 1'b0;
    live_offset.delete();
    live_bytes.delete();
  endtask

  // Offers one transaction, waits for it to be taken and records what it should return.
  task automatic send_item(item_t it, logic typed, result_t want, int unsigned idle_pct);
    result_t predicted;
    int unsigned gap;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 120) : $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predicted = predict_result(it);
    pending_results.push_back(typed ? want : predicted);
    n_sent++;
    if (it.action == ACT_FREE) begin
      n_released++;
    end else if (predicted.ok) begin
      n_granted++;
      live_offset.push_back(predicted.alloc_offset);
      live_bytes.push_back(it.byte_count);
    end else begin
      n_refused++;
    end
  endtask

  // Random traffic: mostly allocations and frees of live runs, with some noise.
  function automatic item_t make_random_item();
    item_t           it;
    int unsigned     pick;
    int unsigned     idx;
    longint unsigned need;
    longint unsigned bytes;
    it = '0;
    pick = $urandom_range(0, 99);
    if (live_offset.size() > 0 && pick < 40) begin
      // Release a live run, now and then only part of it or twice over.
      idx = $urandom_range(0, live_offset.size() - 1);
      it.action = ACT_FREE;
      it.byte_offset = live_offset[idx];
      it.byte_count = live_bytes[idx];
      if ($urandom_range(0, 9) == 0) begin
        it.byte_count = BYTES_W'($urandom_range(0, live_bytes[idx]));
      end
      if ($urandom_range(0, 9) != 0) begin
        live_offset.delete(idx);
        live_bytes.delete(idx);
      end
    end else if (pick < 88) begin
      it.action = ACT_ALLOC;
      it.byte_offset = OFF_W'($urandom_range(0, 262143));
      need = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 70);
      if (cur_size == 0) begin
        bytes = $urandom_range(1, 4096);
      end else begin
        bytes = (need - 1) * cur_size + $urandom_range(1, cur_size);
      end
      it.byte_count = BYTES_W'((bytes > MAX_BYTES) ? MAX_BYTES : bytes);
    end else begin
      case ($urandom_range(0, 4))
        0: begin
          it.action = ACT_ALLOC;
          it.byte_offset = OFF_W'($urandom_range(0, 262143));
        end
        1: begin
          it.action = ACT_ALLOC;
          it.byte_count = BYTES_W'(MAX_BYTES);
        end
        2: begin
          it.action = ACT_FREE;
          it.byte_count = BYTES_W'(MAX_BYTES);
          live_offset.delete();
          live_bytes.delete();
        end
        default: begin
          it.action = ACT_FREE;
          it.byte_count = BYTES_W'($urandom_range(0, 262144));
          it.byte_offset = OFF_W'($urandom_range(0, 262143));
        end
      endcase
    end
    return it;
  endfunction

  // Stimulus: reset, the directed table, then random traffic per block size.
  initial begin
    item_t       it;
    result_t     none;
    int unsigned i;
    int unsigned s;
    int unsigned idle_pct;
    int unsigned per_size;
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    use_map = '0;
    cur_size = SIZE_RESET;
    none = '0;
    errors = 0;
    n_results = 0;
    n_sent = 0;
    n_granted = 0;
    n_refused = 0;
    n_released = 0;

    // Directed table, starting from the reset block size.
    add_item(ACT_ALLOC, 0,      0,      1, 0, 0);
    add_item(ACT_ALLOC, 1,      0,      1, 1, 0);
    add_item(ACT_ALLOC, 64,     0,      1, 1, 64);
    add_item(ACT_ALLOC, 65,     0,      1, 1, 128);
    add_item(ACT_FREE,  64,     64,     1, 1, 0);
    add_item(ACT_ALLOC, 64,     262143, 1, 1, 64);
    add_item(ACT_FREE,  0,      0,      1, 1, 0);
    add_item(ACT_ALLOC, 262144, 0,      1, 0, 0);
    add_item(ACT_ALLOC, 4096,   0,      1, 0, 0);
    add_item(ACT_FREE,  262144, 262143, 1, 1, 0);
    add_item(ACT_FREE,  262144, 0,      1, 1, 0);
    add_item(ACT_ALLOC, 4096,   0,      1, 1, 0);
    add_item(ACT_FREE,  64,     4032,   1, 1, 0);
    add_item(ACT_ALLOC, 65,     0,      1, 0, 0);
    add_item(ACT_ALLOC, 64,     0,      1, 1, 4032);
    add_item(ACT_FREE,  262144, 0,      1, 1, 0);
    // A zero block size refuses every allocation.
    add_cfg(0);
    add_item(ACT_ALLOC, 100,    0,      1, 0, 0);
    add_item(ACT_FREE,  100,    0,      1, 1, 0);
    // The widest block size: a run starting at block 33 has no valid offset.
    add_cfg(8191);
    add_item(ACT_ALLOC, 262144, 0,      1, 1, 0);
    add_item(ACT_ALLOC, 1,      0,      1, 0, 0);
    add_item(ACT_FREE,  1,      262112, 1, 1, 0);
    add_item(ACT_ALLOC, 1,      0,      1, 1, 262112);
    add_cfg(1);
    add_item(ACT_FREE,  262144, 0,      1, 1, 0);
    add_item(ACT_ALLOC, 5,      0,      1, 1, 0);
    add_item(ACT_ALLOC, 1,      0,      1, 1, 5);
    add_cfg(4096);
    add_item(ACT_ALLOC, 4097,   0,      0, 0, 0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < dir_rows.size(); i++) begin
      if (dir_rows[i].is_cfg) begin
        write_block_size(dir_rows[i].size);
      end else begin
        send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want, 22);
      end
    end

    // Random part: each nonzero block size starts from an emptied pool.
    size_plan = '{1, 4096, 64, 8191, 0, 3, 100, 4097, 0};
    size_plan[8] = $urandom_range(1, 8191);
    per_size = RANDOM_ITEMS / 9;
    for (s = 0; s < 9; s++) begin
      write_block_size(SIZE_W'(size_plan[s]));
      it = '0;
      it.action = ACT_FREE;
      it.byte_count = BYTES_W'(MAX_BYTES);
      send_item(it, 1'b0, none, 0);
      for (i = 0; i < per_size; i++) begin
        if (s < 3) begin
          idle_pct = 22;
        end else if (s < 6) begin
          idle_pct = 45;
        end else begin
          idle_pct = 0;
        end
        send_item(make_random_item(), 1'b0, none, idle_pct);
      end
    end

    // Drain: wait for every result, then allow for a late stray strobe.
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Sent %0d transactions over 13 block size settings, zero and 8191 included.",
             n_sent);
    $display("Allocations granted %0d, refused %0d; frees %0d; results checked %0d.",
             n_granted, n_refused, n_released, n_results);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
